FILE: design/top_k_score_keeper_defines.svh
// Assertion macros shared by the top-K score keeper RTL.
`ifndef TOP_K_SCORE_KEEPER_DEFINES_SVH
`define TOP_K_SCORE_KEEPER_DEFINES_SVH

// same-cycle implication
`define TKSK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKSK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/tksk_pkg.sv
// Shared types and constants of the top-K score keeper.
`default_nettype none

package tksk_pkg;

  localparam int CFG_BITS        = 5;
  localparam int LIMIT_BITS      = 8;
  localparam int RESET_MAX_COUNT = 10;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TST_RD,
    ST_TST_CMP,
    ST_EV_RD,
    ST_EV_CAP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic added;
    logic evicted;
  } flags_t;

endpackage

`default_nettype wire

FILE: design/tksk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tksk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/tksk_seq.sv
// Sequencer: tests items, evicts when full, and shifts and inserts entries of the sorted store one slot per step.
`default_nettype none

`include "top_k_score_keeper_defines.svh"

module tksk_seq #(
  parameter int CAPACITY   = 16,
  parameter int SCORE_BITS = 16,
  parameter int ID_BITS    = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int DW = SCORE_BITS + ID_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_op,
  input  wire logic [SCORE_BITS-1:0]           in_score,
  input  wire logic [ID_BITS-1:0]              in_item_id,
  input  wire logic [tksk_pkg::LIMIT_BITS-1:0] limit,
  input  wire logic                            out_free,
  output logic                                 done,
  output tksk_pkg::flags_t                     flags,
  output logic      [ID_BITS-1:0]              ev_id,
  output logic      [SCORE_BITS-1:0]           ev_score,
  output logic      [CW-1:0]                   fill_count,
  output logic                                 ram_we,
  output logic      [AW-1:0]                   ram_waddr,
  output logic      [DW-1:0]                   ram_wdata,
  output logic                                 ram_re,
  output logic      [AW-1:0]                   ram_raddr,
  input  wire logic [DW-1:0]                   ram_rdata
);

  tksk_pkg::state_t  state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [SCORE_BITS-1:0] score_r, score_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  tksk_pkg::flags_t  flags_r, flags_nxt;
  logic [ID_BITS-1:0]    ev_id_r, ev_id_nxt;
  logic [SCORE_BITS-1:0] ev_score_r, ev_score_nxt;

  logic              full;
  logic [CW-1:0]     km1;
  logic [SCORE_BITS-1:0] rd_score;
  logic [ID_BITS-1:0]    rd_id;
  logic              rd_above;

  assign full     = tksk_pkg::LIMIT_BITS'(count_r) >= limit;
  assign km1      = k_r - CW'(1);
  assign rd_score = ram_rdata[DW-1:ID_BITS];
  assign rd_id    = ram_rdata[ID_BITS-1:0];
  assign rd_above = rd_score > score_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tksk_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == tksk_pkg::OP_TEST) begin
            state_nxt = full ? tksk_pkg::ST_TST_RD : tksk_pkg::ST_DONE;
          end else begin
            state_nxt = full ? tksk_pkg::ST_EV_RD : tksk_pkg::ST_INS_RD;
          end
        end
      end
      tksk_pkg::ST_TST_RD:  state_nxt = tksk_pkg::ST_TST_CMP;
      tksk_pkg::ST_TST_CMP: state_nxt = tksk_pkg::ST_DONE;
      tksk_pkg::ST_EV_RD:   state_nxt = tksk_pkg::ST_EV_CAP;
      tksk_pkg::ST_EV_CAP:  state_nxt = tksk_pkg::ST_SH_RD;
      tksk_pkg::ST_SH_RD:   state_nxt = (k_r < n_r) ? tksk_pkg::ST_SH_WR : tksk_pkg::ST_INS_RD;
      tksk_pkg::ST_SH_WR:   state_nxt = tksk_pkg::ST_SH_RD;
      tksk_pkg::ST_INS_RD:  state_nxt = (k_r != '0) ? tksk_pkg::ST_INS_CMP : tksk_pkg::ST_DONE;
      tksk_pkg::ST_INS_CMP: state_nxt = rd_above ? tksk_pkg::ST_INS_RD : tksk_pkg::ST_DONE;
      tksk_pkg::ST_DONE:    state_nxt = out_free ? tksk_pkg::ST_IDLE : tksk_pkg::ST_DONE;
      default:              state_nxt = tksk_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    done      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = k_r[AW-1:0];
    ram_wdata = {score_r, id_r};
    ram_re    = 1'b0;
    ram_raddr = k_r[AW-1:0];
    case (state_r)
      tksk_pkg::ST_IDLE: in_ready = 1'b1;
      tksk_pkg::ST_TST_RD, tksk_pkg::ST_EV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      tksk_pkg::ST_SH_RD: ram_re = k_r < n_r;
      tksk_pkg::ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = km1[AW-1:0];
        ram_wdata = ram_rdata;
      end
      tksk_pkg::ST_INS_RD: begin
        ram_re    = k_r != '0;
        ram_raddr = km1[AW-1:0];
        ram_we    = k_r == '0;
      end
      tksk_pkg::ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = rd_above ? ram_rdata : {score_r, id_r};
      end
      tksk_pkg::ST_DONE: done = out_free;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt       = op_r;
    score_nxt    = score_r;
    id_nxt       = id_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    flags_nxt    = flags_r;
    ev_id_nxt    = ev_id_r;
    ev_score_nxt = ev_score_r;
    case (state_r)
      tksk_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_op;
          score_nxt    = in_score;
          id_nxt       = in_item_id;
          n_nxt        = count_r;
          k_nxt        = count_r;
          ev_id_nxt    = '0;
          ev_score_nxt = '0;
          flags_nxt.added   = in_op == tksk_pkg::OP_PUSH;
          flags_nxt.evicted = 1'b0;
          flags_nxt.accept  = (in_op == tksk_pkg::OP_TEST) && !full;
        end
      end
      tksk_pkg::ST_TST_CMP: flags_nxt.accept = score_r > rd_score;
      tksk_pkg::ST_EV_CAP: begin
        flags_nxt.evicted = 1'b1;
        ev_id_nxt         = rd_id;
        ev_score_nxt      = rd_score;
        k_nxt             = CW'(1);
      end
      tksk_pkg::ST_SH_RD: begin
        if (k_r >= n_r) begin
          n_nxt = n_r - CW'(1);
          k_nxt = n_r - CW'(1);
        end
      end
      tksk_pkg::ST_SH_WR: k_nxt = k_r + CW'(1);
      tksk_pkg::ST_INS_RD: begin
        if (k_r == '0) begin
          count_nxt = n_r + CW'(1);
        end
      end
      tksk_pkg::ST_INS_CMP: begin
        if (rd_above) begin
          k_nxt = km1;
        end else begin
          count_nxt = n_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tksk_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    op_r       <= op_nxt;
    score_r    <= score_nxt;
    id_r       <= id_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    flags_r    <= flags_nxt;
    ev_id_r    <= ev_id_nxt;
    ev_score_r <= ev_score_nxt;
  end

  assign flags      = flags_r;
  assign ev_id      = ev_id_r;
  assign ev_score   = ev_score_r;
  assign fill_count = count_r;

  `TKSK_ASSERT_IMP(a_no_rw_clash, ram_we, !ram_re, "store read and written in one cycle")
  `TKSK_ASSERT_NXT(a_test_keeps_count,
                   in_valid && in_ready && (in_op == tksk_pkg::OP_TEST),
                   $stable(count_r), "test item changed the fill count")
  `TKSK_ASSERT_IMP(a_done_push_flag,
                   done, flags_r.added == (op_r == tksk_pkg::OP_PUSH),
                   "added flag disagrees with op")
  `TKSK_ASSERT_IMP(a_count_bound, done, count_r <= CW'(CAPACITY),
                   "fill count above capacity")

endmodule

`default_nettype wire

FILE: design/top_k_score_keeper.sv
// Top level of the bounded top-K score keeper.
// Flow: a test of a store that is not full completes without a store read; a full-store test
//   compares with the lowest entry. A push to a full store evicts the lowest entry and shifts the
//   rest down; then the item is inserted, entries scoring above it moving up one slot each.
// Items are taken only while idle, one at a time; a held result stalls the finish of the next one.
// Reset: fill count cleared, max-count register to 10; store contents are not cleared.
`default_nettype none

module top_k_score_keeper #(
  parameter int CAPACITY   = 16,
  parameter int SCORE_BITS = 16,
  parameter int ID_BITS    = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int DW = SCORE_BITS + ID_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tksk_pkg::CFG_BITS-1:0] cfg_max_count,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [SCORE_BITS-1:0]         in_score,
  input  wire logic [ID_BITS-1:0]            in_item_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_accept_flag,
  output logic                               out_added_flag,
  output logic                               out_evicted_flag,
  output logic      [ID_BITS-1:0]            out_evicted_id,
  output logic      [SCORE_BITS-1:0]         out_evicted_score,
  output logic      [CW-1:0]                 out_fill_count
);

  logic [tksk_pkg::CFG_BITS-1:0]   max_count_r, max_count_nxt;
  logic [tksk_pkg::LIMIT_BITS-1:0] mc_ext, cap_ext, limit;
  logic                            out_valid_r, out_valid_nxt;
  tksk_pkg::flags_t                out_flags_r;
  logic [ID_BITS-1:0]              out_ev_id_r;
  logic [SCORE_BITS-1:0]           out_ev_score_r;
  logic [CW-1:0]                   out_count_r;

  logic                  out_free, done;
  tksk_pkg::flags_t      flags;
  logic [ID_BITS-1:0]    ev_id;
  logic [SCORE_BITS-1:0] ev_score;
  logic [CW-1:0]         fill_count;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DW-1:0]         ram_wdata, ram_rdata;

  assign cfg_ready     = 1'b1;
  assign max_count_nxt = cfg_valid ? cfg_max_count : max_count_r;

  assign mc_ext  = tksk_pkg::LIMIT_BITS'(max_count_r);
  assign cap_ext = tksk_pkg::LIMIT_BITS'(CAPACITY);
  assign limit   = (mc_ext == '0) ? tksk_pkg::LIMIT_BITS'(1) :
                   (mc_ext > cap_ext) ? cap_ext : mc_ext;

  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = done ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  tksk_seq #(
    .CAPACITY  (CAPACITY),
    .SCORE_BITS(SCORE_BITS),
    .ID_BITS   (ID_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_score  (in_score),
    .in_item_id(in_item_id),
    .limit     (limit),
    .out_free  (out_free),
    .done      (done),
    .flags     (flags),
    .ev_id     (ev_id),
    .ev_score  (ev_score),
    .fill_count(fill_count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tksk_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= tksk_pkg::CFG_BITS'(tksk_pkg::RESET_MAX_COUNT);
      out_valid_r <= 1'b0;
    end else begin
      max_count_r <= max_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (done) begin
      out_flags_r    <= flags;
      out_ev_id_r    <= ev_id;
      out_ev_score_r <= ev_score;
      out_count_r    <= fill_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accept_flag   = out_flags_r.accept;
  assign out_added_flag    = out_flags_r.added;
  assign out_evicted_flag  = out_flags_r.evicted;
  assign out_evicted_id    = out_ev_id_r;
  assign out_evicted_score = out_ev_score_r;
  assign out_fill_count    = out_count_r;

endmodule

`default_nettype wire
